// File: src/rhnd_pkg.sv
package rhnd_pkg;

  // payload widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned SEQ_W  = 16;

  // configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic        REG_CODEC = 1'b0;

  // byte positions within the packet
  localparam logic [POS_W-1:0] POS_SEQ_HI    = 4'd2;
  localparam logic [POS_W-1:0] POS_SEQ_LO    = 4'd3;
  localparam logic [POS_W-1:0] POS_SEQ_CHECK = 4'd11;
  localparam logic [POS_W-1:0] RTP_HDR_LEN   = 4'd12;
  localparam logic [POS_W-1:0] POS_FU_HDR1   = 4'd13;
  localparam logic [POS_W-1:0] POS_FU_HDR    = 4'd14;
  localparam logic [POS_W-1:0] POS_MAX       = 4'd15;

  // payload header codes
  localparam logic [5:0]        FU_TYPE     = 6'd49;
  localparam logic [BYTE_W-1:0] HDR_KEEP    = 8'h81;
  localparam logic [BYTE_W-1:0] SC_LAST     = 8'h01;
  localparam int unsigned       FU_BIT_S    = 7;
  localparam int unsigned       FU_BIT_E    = 6;

  // result slots of one input byte, emitted in this order
  localparam int unsigned NSLOT      = 8;
  localparam int unsigned SLOT_ABORT = 0;
  localparam int unsigned SLOT_SC0   = 1;
  localparam int unsigned SLOT_SC1   = 2;
  localparam int unsigned SLOT_SC2   = 3;
  localparam int unsigned SLOT_SC3   = 4;
  localparam int unsigned SLOT_D0    = 5;
  localparam int unsigned SLOT_D1    = 6;
  localparam int unsigned SLOT_END   = 7;

  typedef enum logic [1:0] {
    MODE_DROP   = 2'd0,
    MODE_AWAIT  = 2'd1,
    MODE_SINGLE = 2'd2,
    MODE_FU     = 2'd3
  } mode_t;

endpackage

// File: src/rhnd_if.sv
interface rhnd_pkt_if;
  import rhnd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pkt_byte;
  logic              pkt_last;

  modport source (output valid, pkt_byte, pkt_last, input ready);
  modport sink (input valid, pkt_byte, pkt_last, output ready);
endinterface

interface rhnd_nal_if;
  import rhnd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] nal_byte;
  logic              byte_valid;
  logic              nal_end;
  logic              nal_abort;
  logic              run_last;

  modport source (output valid, nal_byte, byte_valid, nal_end, nal_abort, run_last,
                  input ready);
  modport sink (input valid, nal_byte, byte_valid, nal_end, nal_abort, run_last,
                output ready);
endinterface

// File: src/rtp_hevc_nal_depacketizer.sv
// RTP to Annex-B HEVC depacketizer. Packet bytes enter on pkt, header first, pkt_last
// on the final byte; the NAL byte stream leaves on nal, one result per beat, with
// run_last on the final result caused by an input byte. A byte is held in an input
// register, decoded in one pass and its results (abort, start code, header bytes,
// data byte, end marker) are loaded into a result register that drains one beat per
// cycle while nal is ready and holds a byte's results until the last has left, so the
// sustained rate is one packet byte per cycle on payload bytes while nal accepts every
// beat. A further input byte is taken while results wait. codec_is_h265 sits at APB
// byte address 0; the user must see that it is written only while idle (unchecked).
module rtp_hevc_nal_depacketizer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rhnd_pkg::APB_AW-1:0] paddr,
  input  logic [rhnd_pkg::APB_DW-1:0] pwdata,
  output logic [rhnd_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  rhnd_pkt_if.sink                  pkt,
  rhnd_nal_if.source                nal
);
  import rhnd_pkg::*;

  // configuration register
  logic codec_is_h265;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_CODEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_is_h265 <= 1'b1;
    end else if (cfg_wr) begin
      codec_is_h265 <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1] == REG_CODEC) begin
      prdata[0] = codec_is_h265;
    end
  end

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              advance;

  assign pkt.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pkt.ready) begin
      in_valid <= pkt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.valid && pkt.ready) begin
      in_byte <= pkt.pkt_byte;
      in_last <= pkt.pkt_last;
    end
  end

  // depacketizer state
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [BYTE_W-1:0] seq_high_byte, seq_high_byte_next;
  logic [BYTE_W-1:0] seq_low_byte, seq_low_byte_next;
  logic [SEQ_W-1:0]  previous_sequence, previous_sequence_next;
  logic              first_packet_pending, first_packet_pending_next;
  logic              fragment_open, fragment_open_next;
  mode_t             packet_mode, packet_mode_next;
  logic [BYTE_W-1:0] held_hdr0, held_hdr0_next;
  logic [BYTE_W-1:0] held_hdr1, held_hdr1_next;
  logic              end_flag_pending, end_flag_pending_next;

  // result register contents for the byte now decoded
  logic [NSLOT-1:0]  slot_mask_next;
  logic [BYTE_W-1:0] d0_next, d1_next;
  logic              end0_next, end1_next;

  // decode of one packet byte
  always_comb begin
    logic [SEQ_W-1:0] cur_seq;
    logic             seq_ok;
    logic             frag_begin;
    logic             frag_tmp;
    logic             endf_tmp;

    byte_position_next        = byte_position;
    seq_high_byte_next        = seq_high_byte;
    seq_low_byte_next         = seq_low_byte;
    previous_sequence_next    = previous_sequence;
    first_packet_pending_next = first_packet_pending;
    packet_mode_next          = packet_mode;
    held_hdr0_next            = held_hdr0;
    held_hdr1_next            = held_hdr1;
    frag_tmp                  = fragment_open;
    endf_tmp                  = end_flag_pending;
    slot_mask_next            = '0;
    d0_next                   = in_byte;
    d1_next                   = held_hdr1;
    end0_next                 = 1'b0;
    end1_next                 = 1'b0;
    cur_seq                   = {seq_high_byte, seq_low_byte};
    seq_ok                    = first_packet_pending ||
                                (cur_seq == previous_sequence + SEQ_W'(1));
    frag_begin                = in_byte[FU_BIT_S];

    if (byte_position < RTP_HDR_LEN) begin
      // fixed header: capture sequence number, check it on the last header byte
      if (byte_position == POS_SEQ_HI) begin
        seq_high_byte_next = in_byte;
      end else if (byte_position == POS_SEQ_LO) begin
        seq_low_byte_next = in_byte;
      end else if (byte_position == POS_SEQ_CHECK) begin
        if (seq_ok) begin
          packet_mode_next = codec_is_h265 ? MODE_AWAIT : MODE_DROP;
        end else begin
          packet_mode_next = MODE_DROP;
          if (frag_tmp) begin
            slot_mask_next[SLOT_ABORT] = 1'b1;
            frag_tmp = 1'b0;
          end
        end
        first_packet_pending_next = 1'b0;
        previous_sequence_next    = cur_seq;
      end
    end else begin
      unique case (packet_mode)
        MODE_AWAIT: begin
          if (in_byte[6:1] == FU_TYPE) begin
            held_hdr0_next   = in_byte;
            packet_mode_next = MODE_FU;
          end else begin
            if (frag_tmp) begin
              slot_mask_next[SLOT_ABORT] = 1'b1;
              frag_tmp = 1'b0;
            end
            slot_mask_next[SLOT_SC0] = 1'b1;
            slot_mask_next[SLOT_SC1] = 1'b1;
            slot_mask_next[SLOT_SC2] = 1'b1;
            slot_mask_next[SLOT_SC3] = 1'b1;
            slot_mask_next[SLOT_D0]  = 1'b1;
            end0_next        = in_last;
            packet_mode_next = MODE_SINGLE;
          end
        end
        MODE_SINGLE: begin
          slot_mask_next[SLOT_D0] = 1'b1;
          end0_next = in_last;
        end
        MODE_FU: begin
          if (byte_position == POS_FU_HDR1) begin
            held_hdr1_next = in_byte;
          end else if (byte_position == POS_FU_HDR) begin
            // FU header: rebuild the NAL header on a start fragment
            if (frag_begin) begin
              if (frag_tmp) begin
                slot_mask_next[SLOT_ABORT] = 1'b1;
              end
              slot_mask_next[SLOT_SC0] = 1'b1;
              slot_mask_next[SLOT_SC1] = 1'b1;
              slot_mask_next[SLOT_SC2] = 1'b1;
              slot_mask_next[SLOT_SC3] = 1'b1;
              slot_mask_next[SLOT_D0]  = 1'b1;
              slot_mask_next[SLOT_D1]  = 1'b1;
              d0_next  = (held_hdr0 & HDR_KEEP) | {1'b0, in_byte[5:0], 1'b0};
              frag_tmp = 1'b1;
            end
            if (in_byte[FU_BIT_E] && frag_tmp) begin
              endf_tmp = 1'b1;
            end
            if (in_last && endf_tmp) begin
              if (frag_begin) begin
                end1_next = 1'b1;
              end else begin
                slot_mask_next[SLOT_END] = 1'b1;
              end
            end
          end else begin
            // FU payload
            if (frag_tmp) begin
              slot_mask_next[SLOT_D0] = 1'b1;
              end0_next = in_last && endf_tmp;
            end else if (in_last && endf_tmp) begin
              slot_mask_next[SLOT_END] = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // packet boundary
    if (in_last) begin
      if (endf_tmp) begin
        frag_tmp = 1'b0;
      end
      byte_position_next = '0;
      packet_mode_next   = MODE_DROP;
      endf_tmp           = 1'b0;
    end else if (byte_position != POS_MAX) begin
      byte_position_next = byte_position + POS_W'(1);
    end

    fragment_open_next    = frag_tmp;
    end_flag_pending_next = endf_tmp;
  end

  // result register: one bit per pending result slot
  logic [NSLOT-1:0]  slot_mask;
  logic [BYTE_W-1:0] d0, d1;
  logic              end0, end1;
  logic [NSLOT-1:0]  slot_cur;
  logic              run_done;
  logic              out_beat;

  assign slot_cur = slot_mask & (~slot_mask + NSLOT'(1));
  assign run_done = (slot_mask & ~slot_cur) == '0;
  assign out_beat = nal.valid && nal.ready;
  assign advance  = in_valid && ((slot_mask == '0) || (out_beat && run_done));

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= '0;
      seq_high_byte        <= '0;
      seq_low_byte         <= '0;
      previous_sequence    <= '0;
      first_packet_pending <= 1'b1;
      fragment_open        <= 1'b0;
      packet_mode          <= MODE_DROP;
      end_flag_pending     <= 1'b0;
    end else if (advance) begin
      byte_position        <= byte_position_next;
      seq_high_byte        <= seq_high_byte_next;
      seq_low_byte         <= seq_low_byte_next;
      previous_sequence    <= previous_sequence_next;
      first_packet_pending <= first_packet_pending_next;
      fragment_open        <= fragment_open_next;
      packet_mode          <= packet_mode_next;
      end_flag_pending     <= end_flag_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held_hdr0 <= held_hdr0_next;
      held_hdr1 <= held_hdr1_next;
      d0        <= d0_next;
      d1        <= d1_next;
      end0      <= end0_next;
      end1      <= end1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_mask <= '0;
    end else if (advance) begin
      slot_mask <= slot_mask_next;
    end else if (out_beat) begin
      slot_mask <= slot_mask & ~slot_cur;
    end
  end

  // output beat from the lowest pending slot
  always_comb begin
    nal.valid      = slot_mask != '0;
    nal.byte_valid = |slot_cur[SLOT_D1:SLOT_SC0];
    nal.nal_abort  = slot_cur[SLOT_ABORT];
    nal.nal_end    = slot_cur[SLOT_END] || (slot_cur[SLOT_D0] && end0) ||
                     (slot_cur[SLOT_D1] && end1);
    nal.run_last   = run_done;
    nal.nal_byte   = '0;
    if (slot_cur[SLOT_D0]) begin
      nal.nal_byte = d0;
    end else if (slot_cur[SLOT_D1]) begin
      nal.nal_byte = d1;
    end else if (slot_cur[SLOT_SC3]) begin
      nal.nal_byte = SC_LAST;
    end
  end

  // checks
  a_abort_alone: assert property (@(posedge clk) disable iff (rst)
    nal.valid && nal.nal_abort |-> !nal.byte_valid && !nal.nal_end)
    else $error("abort beat carries data or end");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && (slot_mask != '0) && !(out_beat && run_done) |=> in_valid)
    else $error("input byte lost while results pending");

  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> byte_position == '0 && packet_mode == MODE_DROP)
    else $error("packet state not cleared after last byte");

  a_frag_open: assert property (@(posedge clk) disable iff (rst)
    $rose(fragment_open) |-> $past(advance && slot_mask_next[SLOT_D1]))
    else $error("fragment opened without rebuilt header");

  a_end_has_run: assert property (@(posedge clk) disable iff (rst)
    nal.valid && slot_cur[SLOT_END] |-> run_done)
    else $error("end marker not last in run");

endmodule

// File: dv/rtp_hevc_nal_depacketizer_tb.sv
module rtp_hevc_nal_depacketizer_tb;
  import rhnd_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 16;
  localparam int SETTLE_LIMIT = 4000;
  localparam logic [APB_AW-1:0] CODEC_ADDR = APB_AW'(4 * int'(REG_CODEC));

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } pkt_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] nal_byte;
    logic              byte_valid;
    logic              nal_end;
    logic              nal_abort;
    logic              run_last;
  } nal_beat_t;

  typedef enum int {
    PK_SINGLE, PK_FU_START, PK_FU_MID, PK_FU_END, PK_FU_WHOLE, PK_FU_SHORT, PK_EMPTY, PK_RUNT
  } pkt_kind_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  rhnd_pkt_if pkt_ch ();
  rhnd_nal_if nal_ch ();

  rtp_hevc_nal_depacketizer u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pkt     (pkt_ch.sink),
    .nal     (nal_ch.source)
  );

  // queues between stimulus, depacketizer model and stream checker
  pkt_beat_t pkt_pending_q[$];
  nal_beat_t nal_expect_q[$];
  nal_beat_t step_q[$];
  logic [7:0] build_q[$];

  // depacketizer model state, reset values
  logic [POS_W-1:0]  cur_pos     = '0;
  logic [7:0]        seq_hi      = '0;
  logic [7:0]        seq_lo      = '0;
  logic [SEQ_W-1:0]  last_seq    = '0;
  logic              await_first = 1'b1;
  logic              frag_open   = 1'b0;
  mode_t             pkt_mode    = MODE_DROP;
  logic [7:0]        fu_ind      = '0;
  logic [7:0]        fu_hdr1     = '0;
  logic              end_due     = 1'b0;
  logic              h265_on     = 1'b1;

  // stimulus and bookkeeping
  logic [SEQ_W-1:0] next_seq = '0;
  int  bytes_queued = 0;
  int  packets_sent = 0;
  int  bytes_in     = 0;
  int  beats_out    = 0;
  int  nal_ends     = 0;
  int  aborts       = 0;
  int  codec_writes = 0;
  int  errors       = 0;
  int  hold_from    = 0;
  int  tx_gap       = 0;
  int  rx_gap       = 0;
  logic hold_rx     = 1'b0;
  logic calm        = 1'b0;

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // model: result beats of one packet byte
  function automatic void push_beat(logic [7:0] b, logic v, logic e, logic a);
    step_q.push_back({b, v, e, a, 1'b0});
  endfunction

  function automatic void abort_fragment();
    if (frag_open) begin
      push_beat(8'h00, 1'b0, 1'b0, 1'b1);
      frag_open = 1'b0;
    end
  endfunction

  function automatic void start_code();
    repeat (3) push_beat(8'h00, 1'b1, 1'b0, 1'b0);
    push_beat(SC_LAST, 1'b1, 1'b0, 1'b0);
  endfunction

  // end flag rides on this byte's last data beat, else a beat of its own
  function automatic void close_nal();
    if (step_q.size() > 0 && step_q[step_q.size()-1].byte_valid)
      step_q[step_q.size()-1].nal_end = 1'b1;
    else
      push_beat(8'h00, 1'b0, 1'b1, 1'b0);
  endfunction

  function automatic void predict_beats(logic [7:0] b, logic last);
    logic [POS_W-1:0] p;
    logic [SEQ_W-1:0] cur;
    logic [SEQ_W-1:0] want_seq;
    p = cur_pos;
    step_q.delete();
    if (p < RTP_HDR_LEN) begin
      if (p == POS_SEQ_HI) begin
        seq_hi = b;
      end else if (p == POS_SEQ_LO) begin
        seq_lo = b;
      end else if (p == POS_SEQ_CHECK) begin
        cur = {seq_hi, seq_lo};
        want_seq = last_seq + 16'd1;
        if (await_first || cur == want_seq) begin
          pkt_mode = h265_on ? MODE_AWAIT : MODE_DROP;
        end else begin
          pkt_mode = MODE_DROP;
          abort_fragment();
        end
        await_first = 1'b0;
        last_seq = cur;
      end
    end else if (pkt_mode == MODE_AWAIT) begin
      if (b[6:1] == FU_TYPE) begin
        fu_ind = b;
        pkt_mode = MODE_FU;
      end else begin
        abort_fragment();
        start_code();
        push_beat(b, 1'b1, 1'b0, 1'b0);
        pkt_mode = MODE_SINGLE;
        if (last) close_nal();
      end
    end else if (pkt_mode == MODE_SINGLE) begin
      push_beat(b, 1'b1, 1'b0, 1'b0);
      if (last) close_nal();
    end else if (pkt_mode == MODE_FU) begin
      if (p == POS_FU_HDR1) begin
        fu_hdr1 = b;
      end else if (p == POS_FU_HDR) begin
        // start bit rebuilds the nal header from indicator and fu type
        if (b[FU_BIT_S]) begin
          abort_fragment();
          start_code();
          push_beat((fu_ind & HDR_KEEP) | {1'b0, b[5:0], 1'b0}, 1'b1, 1'b0, 1'b0);
          push_beat(fu_hdr1, 1'b1, 1'b0, 1'b0);
          frag_open = 1'b1;
        end
        if (b[FU_BIT_E] && frag_open) end_due = 1'b1;
        if (last && end_due) close_nal();
      end else begin
        if (frag_open) push_beat(b, 1'b1, 1'b0, 1'b0);
        if (last && end_due) close_nal();
      end
    end
    if (last) begin
      if (end_due) frag_open = 1'b0;
      cur_pos = '0;
      pkt_mode = MODE_DROP;
      end_due = 1'b0;
    end else begin
      cur_pos = (p < POS_MAX) ? p + 4'd1 : POS_MAX;
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
    foreach (step_q[i]) nal_expect_q.push_back(step_q[i]);
  endfunction

  // packet source: sender side with random idle bursts
  always @(posedge clk) begin : drive
    pkt_beat_t nb;
    if (rst) begin
      pkt_ch.valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (pkt_ch.valid && pkt_ch.ready) begin
        predict_beats(pkt_ch.pkt_byte, pkt_ch.pkt_last);
        bytes_in++;
      end
      if (!pkt_ch.valid || pkt_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          pkt_ch.valid <= 1'b0;
        end else if (pkt_pending_q.size() > 0 && !calm && $urandom_range(0, 7) == 0) begin
          tx_gap <= $urandom_range(0, 6);
          pkt_ch.valid <= 1'b0;
        end else if (pkt_pending_q.size() > 0) begin
          nb = pkt_pending_q.pop_front();
          pkt_ch.valid <= 1'b1;
          pkt_ch.pkt_byte <= nb.data;
          pkt_ch.pkt_last <= nb.last;
        end else begin
          pkt_ch.valid <= 1'b0;
        end
      end
    end
  end

  // stream checker: receiver side with random stalls and one long hold-off
  always @(posedge clk) begin : watch
    nal_beat_t got;
    nal_beat_t want;
    if (rst) begin
      nal_ch.ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (nal_ch.valid && nal_ch.ready) begin
        got = {nal_ch.nal_byte, nal_ch.byte_valid, nal_ch.nal_end, nal_ch.nal_abort,
               nal_ch.run_last};
        beats_out++;
        if (got.nal_end) nal_ends++;
        if (got.nal_abort) aborts++;
        if (nal_expect_q.size() == 0) begin
          flag_error($sformatf("beat %0d unexpected: byte %02h valid %b end %b abort %b last %b",
                               beats_out, got.nal_byte, got.byte_valid, got.nal_end,
                               got.nal_abort, got.run_last));
        end else begin
          want = nal_expect_q.pop_front();
          if (got !== want)
            flag_error($sformatf({"beat %0d: expected byte %02h valid %b end %b abort %b ",
                                  "last %b, got byte %02h valid %b end %b abort %b last %b"},
                                 beats_out, want.nal_byte, want.byte_valid, want.nal_end,
                                 want.nal_abort, want.run_last, got.nal_byte,
                                 got.byte_valid, got.nal_end, got.nal_abort, got.run_last));
        end
      end
      if (hold_rx) begin
        nal_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        nal_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rx_gap <= $urandom_range(0, 6);
        nal_ch.ready <= 1'b0;
      end else begin
        nal_ch.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block backs up into the packet input
  initial begin
    wait (hold_from != 0);
    while (bytes_in < hold_from) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // packet building
  function automatic void start_header(logic [SEQ_W-1:0] seq);
    build_q.delete();
    for (int i = 0; i < int'(RTP_HDR_LEN); i++) build_q.push_back(8'($urandom));
    build_q[POS_SEQ_HI] = seq[15:8];
    build_q[POS_SEQ_LO] = seq[7:0];
  endfunction

  function automatic logic [SEQ_W-1:0] take_seq(bit gap);
    logic [SEQ_W-1:0] s;
    s = gap ? next_seq + 16'($urandom_range(1, 65534)) : next_seq;
    next_seq = s + 16'd1;
    return s;
  endfunction

  function automatic void add_payload(int len, int fill);
    repeat (len) build_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
  endfunction

  function automatic void ship();
    foreach (build_q[i]) pkt_pending_q.push_back({build_q[i], 1'(i == build_q.size() - 1)});
    if (build_q.size() >= int'(RTP_HDR_LEN)) bytes_queued += build_q.size();
    packets_sent++;
  endfunction

  function automatic void make_packet(pkt_kind_t kind, bit gap, int len, int fill = -1);
    logic [7:0] b;
    if (kind == PK_RUNT) begin
      // header cut short, sequence left alone
      start_header(16'($urandom));
      b = 8'($urandom_range(1, 11));
      while (build_q.size() > int'(b)) void'(build_q.pop_back());
      ship();
      return;
    end
    start_header(take_seq(gap));
    if (kind == PK_SINGLE) begin
      do b = 8'($urandom); while (b[6:1] == FU_TYPE);
      build_q.push_back(b);
      add_payload(len, fill);
    end else if (kind != PK_EMPTY) begin
      build_q.push_back({1'($urandom), FU_TYPE, 1'($urandom)});
      build_q.push_back(8'($urandom));
      if (kind == PK_FU_SHORT) begin
        if ($urandom_range(0, 1) == 0) void'(build_q.pop_back());
      end else begin
        build_q.push_back({1'(kind == PK_FU_START || kind == PK_FU_WHOLE),
                           1'(kind == PK_FU_END || kind == PK_FU_WHOLE), 6'($urandom)});
        add_payload(len, fill);
      end
    end
    ship();
  endfunction

  function automatic int pick_len();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
  endfunction

  // mostly well-formed nal units and fragment runs, some noise
  function automatic void queue_traffic(int budget);
    int start;
    int r;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        make_packet(PK_SINGLE, 1'b0, pick_len());
      end else if (r < 65) begin
        make_packet(PK_FU_START, 1'b0, pick_len());
        repeat ($urandom_range(0, 2)) make_packet(PK_FU_MID, 1'b0, pick_len());
        make_packet(PK_FU_END, 1'b0, pick_len());
      end else if (r < 70) begin
        make_packet(r[0] ? PK_SINGLE : PK_FU_START, 1'b1, pick_len());
      end else if (r < 74) begin
        make_packet(PK_RUNT, 1'b0, 0);
      end else if (r < 78) begin
        make_packet(PK_EMPTY, 1'b0, 0);
      end else if (r < 84) begin
        make_packet(PK_FU_WHOLE, 1'b0, pick_len());
      end else if (r < 89) begin
        make_packet(PK_FU_START, 1'b0, pick_len());
      end else if (r < 95) begin
        make_packet(r[0] ? PK_FU_MID : PK_FU_END, 1'b0, pick_len());
      end else begin
        make_packet(PK_FU_SHORT, 1'b0, 0);
      end
    end
  endfunction

  // wait until the block has drained everything it owes, bounded
  task automatic settle();
    for (int i = 0; i < SETTLE_LIMIT &&
         (pkt_pending_q.size() != 0 || pkt_ch.valid || nal_expect_q.size() != 0); i++)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_codec(logic v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CODEC_ADDR;
    pwdata  <= APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    h265_on = v;
    codec_writes++;
  endtask

  // overall run
  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pkt_ch.valid = 1'b0;
    pkt_ch.pkt_byte = '0;
    pkt_ch.pkt_last = 1'b0;
    nal_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: h265 mode from reset, sequence wrap, gap and stray fragment end
    make_packet(PK_RUNT, 1'b0, 0);
    next_seq = 16'hFFFF;
    make_packet(PK_SINGLE, 1'b0, 1, 8'hFF);
    make_packet(PK_FU_START, 1'b0, 0);
    make_packet(PK_FU_START, 1'b1, 0);
    make_packet(PK_FU_END, 1'b0, 0);
    make_packet(PK_FU_START, 1'b0, 0);
    settle();

    // sequence-only mode, fragment left open from above
    write_codec(1'b0);
    queue_traffic(1);
    settle();

    // h265 with idling and one long receiver hold-off
    write_codec(1'b1);
    hold_from = bytes_in + 8;
    queue_traffic(24);
    settle();

    // closing stretch at full rate
    calm = 1'b1;
    queue_traffic(1);
    settle();

    if (nal_expect_q.size() != 0)
      flag_error($sformatf("%0d expected beats never arrived", nal_expect_q.size()));
    $display("covered %0d packets, %0d packet bytes in, %0d stream beats checked",
             packets_sent, bytes_in, beats_out);
    $display("saw %0d nal ends and %0d aborts over %0d codec writes, one %0d-cycle hold-off",
             nal_ends, aborts, codec_writes, HOLD_CYCLES);
    if (errors == 0) begin
      $display("PASS rtp_hevc_nal_depacketizer");
    end else begin
      $display("FAIL rtp_hevc_nal_depacketizer");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAIL rtp_hevc_nal_depacketizer");
    $finish;
  end

endmodule
